/* src/aat_pkg.sv */
// Shared constants for the affine box transform pipeline.
package aat_pkg;

    // Default datapath widths
    localparam int COORD_WIDTH = 32;
    localparam int COEFF_WIDTH = 16;

    // Coefficients carry four integer bits
    localparam int COEFF_INT_BITS = 4;

    // Configuration register index codes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

endpackage

/* src/aat_in_if.sv */
// Input box channel: valid/ready with the lower and upper corners.
interface aat_in_if #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_min_z;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_max_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

/* src/aat_out_if.sv */
// Output box channel: valid/ready with the enclosing box corners.
interface aat_out_if #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_min_x;
    logic signed [COORD_WIDTH-1:0] out_min_y;
    logic signed [COORD_WIDTH-1:0] out_min_z;
    logic signed [COORD_WIDTH-1:0] out_max_x;
    logic signed [COORD_WIDTH-1:0] out_max_y;
    logic signed [COORD_WIDTH-1:0] out_max_z;

    modport source (
        output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
        input  ready
    );
    modport sink (
        input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
        output ready
    );
endinterface

/* src/aat_cfg_regs.sv */
// Transform configuration registers: three coefficient rows and a translation.
module aat_cfg_regs #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH,
    parameter int COEFF_WIDTH = aat_pkg::COEFF_WIDTH,
    parameter int CFG_W       = 3 * COEFF_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]                  i_cfg_data,
    output logic signed [COEFF_WIDTH-1:0]     o_coef [3][3],
    output logic signed [COORD_WIDTH-1:0]     o_shift [3]
);
    localparam int ROW_W = 3 * COEFF_WIDTH;
    localparam logic [COEFF_WIDTH-1:0] ONE =
        COEFF_WIDTH'(1) << (COEFF_WIDTH - aat_pkg::COEFF_INT_BITS);

    logic [ROW_W-1:0]       r_row [3];
    logic [COORD_WIDTH-1:0] r_shift [3];

    // Register writes; reset loads the identity transform
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= ROW_W'(ONE);
            r_row[1]   <= ROW_W'(ONE) << COEFF_WIDTH;
            r_row[2]   <= ROW_W'(ONE) << (2 * COEFF_WIDTH);
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aat_pkg::REG_ROW_X:   r_row[0]   <= i_cfg_data[ROW_W-1:0];
                aat_pkg::REG_ROW_Y:   r_row[1]   <= i_cfg_data[ROW_W-1:0];
                aat_pkg::REG_ROW_Z:   r_row[2]   <= i_cfg_data[ROW_W-1:0];
                aat_pkg::REG_SHIFT_X: r_shift[0] <= i_cfg_data[COORD_WIDTH-1:0];
                aat_pkg::REG_SHIFT_Y: r_shift[1] <= i_cfg_data[COORD_WIDTH-1:0];
                aat_pkg::REG_SHIFT_Z: r_shift[2] <= i_cfg_data[COORD_WIDTH-1:0];
                default: ; // unknown index: ignored
            endcase
        end
    end

    // Unpack rows into coefficients (input x in the low field)
    for (genvar a = 0; a < 3; a++) begin : g_axis
        for (genvar j = 0; j < 3; j++) begin : g_col
            assign o_coef[a][j] = $signed(r_row[a][j*COEFF_WIDTH +: COEFF_WIDTH]);
        end
        assign o_shift[a] = $signed(r_shift[a]);
    end
endmodule

/* src/aat_sort.sv */
// Stage 1: order each min/max pair so swapped bounds span the same box.
module aat_sort #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_lo [3],
    input  logic signed [COORD_WIDTH-1:0] i_hi [3],
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_lo [3],
    output logic signed [COORD_WIDTH-1:0] o_hi [3]
);
    logic                          r_valid;
    logic signed [COORD_WIDTH-1:0] r_lo [3];
    logic signed [COORD_WIDTH-1:0] r_hi [3];
    logic signed [COORD_WIDTH-1:0] n_lo [3];
    logic signed [COORD_WIDTH-1:0] n_hi [3];

    assign o_ready = !r_valid || i_ready;

    // Per-axis compare and swap
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (i_lo[j] < i_hi[j]) begin
                n_lo[j] = i_lo[j];
                n_hi[j] = i_hi[j];
            end else begin
                n_lo[j] = i_hi[j];
                n_hi[j] = i_lo[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    assign o_valid = r_valid;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;
endmodule

/* src/aat_mul.sv */
// Stage 2: pick the bound per coefficient sign and form the exact products.
module aat_mul #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH,
    parameter int COEFF_WIDTH = aat_pkg::COEFF_WIDTH,
    parameter int PROD_W      = COORD_WIDTH + COEFF_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_lo [3],
    input  logic signed [COORD_WIDTH-1:0] i_hi [3],
    input  logic signed [COEFF_WIDTH-1:0] i_coef [3][3],
    output logic                          o_valid,
    input  logic                          i_ready,
    // [output axis][0 = lower, 1 = upper][input axis]
    output logic signed [PROD_W-1:0]      o_prod [3][2][3]
);
    logic                          r_valid;
    logic signed [PROD_W-1:0]      r_prod [3][2][3];
    logic signed [PROD_W-1:0]      n_prod [3][2][3];
    logic signed [COORD_WIDTH-1:0] sel;

    assign o_ready = !r_valid || i_ready;

    // Lower bound takes min for c >= 0, max otherwise; upper the reverse
    always_comb begin
        sel = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 2; b++) begin
                for (int j = 0; j < 3; j++) begin
                    if (i_coef[a][j][COEFF_WIDTH-1] == b[0]) begin
                        sel = i_lo[j];
                    end else begin
                        sel = i_hi[j];
                    end
                    n_prod[a][b][j] = PROD_W'(sel) * PROD_W'(i_coef[a][j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
endmodule

/* src/aat_sum.sv */
// Stage 3: add the three products and the scaled translation per bound.
module aat_sum #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH,
    parameter int COEFF_WIDTH = aat_pkg::COEFF_WIDTH,
    parameter int PROD_W      = COORD_WIDTH + COEFF_WIDTH,
    parameter int SUM_W       = PROD_W + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [PROD_W-1:0]      i_prod [3][2][3],
    input  logic signed [COORD_WIDTH-1:0] i_shift [3],
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SUM_W-1:0]       o_sum [3][2]
);
    localparam int FRAC = COEFF_WIDTH - aat_pkg::COEFF_INT_BITS;

    logic                    r_valid;
    logic signed [SUM_W-1:0] r_sum [3][2];
    logic signed [SUM_W-1:0] n_sum [3][2];

    assign o_ready = !r_valid || i_ready;

    // Exact sum in coefficient-fraction units
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 2; b++) begin
                n_sum[a][b] = SUM_W'(i_prod[a][b][0]) + SUM_W'(i_prod[a][b][1])
                            + SUM_W'(i_prod[a][b][2]) + (SUM_W'(i_shift[a]) <<< FRAC);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;
endmodule

/* src/aat_round.sv */
// Stage 4: floor the lower bound, ceil the upper bound, saturate; output register.
module aat_round #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH,
    parameter int COEFF_WIDTH = aat_pkg::COEFF_WIDTH,
    parameter int SUM_W       = COORD_WIDTH + COEFF_WIDTH + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SUM_W-1:0]       i_sum [3][2],
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_res [3][2]
);
    localparam int FRAC = COEFF_WIDTH - aat_pkg::COEFF_INT_BITS;
    localparam logic signed [SUM_W-1:0] MAXV =
        {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MINV = ~MAXV;
    localparam logic signed [SUM_W-1:0] BIAS = (SUM_W'(1) << FRAC) - SUM_W'(1);

    logic                          r_valid;
    logic signed [COORD_WIDTH-1:0] r_res [3][2];
    logic signed [COORD_WIDTH-1:0] n_res [3][2];
    logic signed [SUM_W-1:0]       rnd;

    assign o_ready = !r_valid || i_ready;

    // Round toward the outside of the box, then clamp to the coordinate range
    always_comb begin
        rnd = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 2; b++) begin
                if (b == 0) begin
                    rnd = i_sum[a][b] >>> FRAC;
                end else begin
                    rnd = (i_sum[a][b] + BIAS) >>> FRAC;
                end
                if (rnd > MAXV) begin
                    n_res[a][b] = MAXV[COORD_WIDTH-1:0];
                end else if (rnd < MINV) begin
                    n_res[a][b] = MINV[COORD_WIDTH-1:0];
                end else begin
                    n_res[a][b] = rnd[COORD_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

/* src/affine_aabb_transform_top.sv */
// Top level of the affine bounding box transform pipeline.
//
// Usage: boxes enter on i_box (valid/ready, min and max corners) and the
// enclosing box of the transformed corners leaves on o_box (valid/ready).
// The transform is loaded through i_cfg_we / i_cfg_idx / i_cfg_data:
// indexes 0..2 hold the coefficient rows for output x, y, z, indexes 3..5
// the translation; other indexes are ignored. Write it only while idle.
// Stages: sort, multiply, add, round/saturate, each a register stage;
// the last is the output reg.
// Throughput: one item per cycle while o_box.ready is high, set by the
// four-stage pipe with 18 parallel multipliers in the multiply stage.
// Reset (i_rst_n low, synchronous) empties the pipe and loads the identity
// transform with zero translation.
// Stalls: when o_box.ready is low the result holds; ready back-pressure
// fills the bubbles stage by stage, so up to four items sit in the pipe
// before i_box.ready drops. Nothing is lost or repeated.
module affine_aabb_transform_top #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH,
    parameter int COEFF_WIDTH = aat_pkg::COEFF_WIDTH,
    parameter int CFG_W = (3 * COEFF_WIDTH > COORD_WIDTH) ? 3 * COEFF_WIDTH : COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    aat_in_if.sink                        i_box,
    aat_out_if.source                     o_box,
    input  logic                          i_cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data
);
    localparam int PROD_W = COORD_WIDTH + COEFF_WIDTH;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [COEFF_WIDTH-1:0] coef [3][3];
    logic signed [COORD_WIDTH-1:0] shift [3];

    logic signed [COORD_WIDTH-1:0] in_lo [3];
    logic signed [COORD_WIDTH-1:0] in_hi [3];
    logic signed [COORD_WIDTH-1:0] s1_lo [3];
    logic signed [COORD_WIDTH-1:0] s1_hi [3];
    logic signed [PROD_W-1:0]      s2_prod [3][2][3];
    logic signed [SUM_W-1:0]       s3_sum [3][2];
    logic signed [COORD_WIDTH-1:0] s4_res [3][2];

    logic s1_valid, s1_ready;
    logic s2_valid, s2_ready;
    logic s3_valid, s3_ready;

    // Configuration
    aat_cfg_regs #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEFF_WIDTH(COEFF_WIDTH),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_coef    (coef),
        .o_shift   (shift)
    );

    // Input corners as arrays by axis
    assign in_lo[0] = i_box.box_min_x;
    assign in_lo[1] = i_box.box_min_y;
    assign in_lo[2] = i_box.box_min_z;
    assign in_hi[0] = i_box.box_max_x;
    assign in_hi[1] = i_box.box_max_y;
    assign in_hi[2] = i_box.box_max_z;

    aat_sort #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_sort (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_box.valid),
        .o_ready(i_box.ready),
        .i_lo   (in_lo),
        .i_hi   (in_hi),
        .o_valid(s1_valid),
        .i_ready(s1_ready),
        .o_lo   (s1_lo),
        .o_hi   (s1_hi)
    );

    aat_mul #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEFF_WIDTH(COEFF_WIDTH),
        .PROD_W     (PROD_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s1_valid),
        .o_ready(s1_ready),
        .i_lo   (s1_lo),
        .i_hi   (s1_hi),
        .i_coef (coef),
        .o_valid(s2_valid),
        .i_ready(s2_ready),
        .o_prod (s2_prod)
    );

    aat_sum #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEFF_WIDTH(COEFF_WIDTH),
        .PROD_W     (PROD_W),
        .SUM_W      (SUM_W)
    ) u_sum (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s2_valid),
        .o_ready(s2_ready),
        .i_prod (s2_prod),
        .i_shift(shift),
        .o_valid(s3_valid),
        .i_ready(s3_ready),
        .o_sum  (s3_sum)
    );

    aat_round #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEFF_WIDTH(COEFF_WIDTH),
        .SUM_W      (SUM_W)
    ) u_round (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s3_valid),
        .o_ready(s3_ready),
        .i_sum  (s3_sum),
        .o_valid(o_box.valid),
        .i_ready(o_box.ready),
        .o_res  (s4_res)
    );

    // Result corners
    assign o_box.out_min_x = s4_res[0][0];
    assign o_box.out_min_y = s4_res[1][0];
    assign o_box.out_min_z = s4_res[2][0];
    assign o_box.out_max_x = s4_res[0][1];
    assign o_box.out_max_y = s4_res[1][1];
    assign o_box.out_max_z = s4_res[2][1];
endmodule

/* verif/tb_affine_aabb_transform_top.sv */
// Testbench for the affine bounding box transform: random and directed boxes, scoreboard check.
`timescale 1ns / 100ps

module tb_affine_aabb_transform_top;

    localparam int COORD_WIDTH    = aat_pkg::COORD_WIDTH;
    localparam int COEFF_WIDTH    = aat_pkg::COEFF_WIDTH;
    localparam int CFG_IDX_W      = aat_pkg::CFG_IDX_W;
    localparam int CFG_W          = 3 * COEFF_WIDTH;
    localparam int FRAC_BITS      = COEFF_WIDTH - aat_pkg::COEFF_INT_BITS;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_LEN       = 80;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_BOXES  = 238;

    // Indexes outside the register map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [COEFF_WIDTH-1:0] t_coeff;
    // Box layout: 0..2 lower x,y,z, 3..5 upper x,y,z
    typedef logic [5:0][COORD_WIDTH-1:0]   t_box;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coeff COEFF_MAX = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
    localparam t_coeff COEFF_MIN = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
    localparam t_coeff COEFF_ONE = t_coeff'(1 << FRAC_BITS);

    logic               i_clk       = 1'b0;
    logic               rst_n       = 1'b0;
    logic               box_valid   = 1'b0;
    t_box               box_data    = '0;
    logic               box_taken   = 1'b0;
    logic               result_ready = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]   cfg_data    = '0;

    // Transform as the block should hold it
    logic [CFG_W-1:0]   coeff_row [3];
    t_coord             shift_val [3];

    t_box               boxes_to_send [$];
    t_box               expected_bounds [$];
    int                 boxes_queued   = 0;
    int                 boxes_accepted = 0;
    int                 error_count    = 0;
    int                 idle_cycles    = 0;
    int                 tx_idle_pct    = 0;
    int                 rx_idle_pct    = 0;
    logic               pressure_on    = 1'b0;
    logic               pressure_done  = 1'b0;
    int                 hold_count     = 0;

    string field_name [6] = '{"out_min_x", "out_min_y", "out_min_z",
                              "out_max_x", "out_max_y", "out_max_z"};

    aat_in_if  in_ch ();
    aat_out_if out_ch ();

    assign in_ch.valid     = box_valid;
    assign in_ch.box_min_x = box_data[0];
    assign in_ch.box_min_y = box_data[1];
    assign in_ch.box_min_z = box_data[2];
    assign in_ch.box_max_x = box_data[3];
    assign in_ch.box_max_y = box_data[4];
    assign in_ch.box_max_z = box_data[5];
    assign out_ch.ready    = result_ready;

    affine_aabb_transform_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_box      (in_ch),
        .o_box      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_coord clamp_coord(logic signed [63:0] v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return t_coord'(v);
    endfunction

    // Enclosing box: per term pick the bound that minimizes or maximizes coeff*bound,
    // floor the lower sum, ceil the upper sum, add translation, saturate.
    function automatic t_box enclose_box(t_box b);
        t_box               r;
        t_coord             lo, hi, tmp;
        t_coeff             c;
        logic signed [63:0] sum_lo, sum_hi;
        int                 a, j;
        for (a = 0; a < 3; a++) begin
            sum_lo = 0;
            sum_hi = 0;
            for (j = 0; j < 3; j++) begin
                c  = coeff_row[a][j*COEFF_WIDTH +: COEFF_WIDTH];
                lo = b[j];
                hi = b[3+j];
                if (lo > hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                if (c >= 0) begin
                    sum_lo = sum_lo + c * lo;
                    sum_hi = sum_hi + c * hi;
                end else begin
                    sum_lo = sum_lo + c * hi;
                    sum_hi = sum_hi + c * lo;
                end
            end
            r[a]   = clamp_coord((sum_lo >>> FRAC_BITS) + shift_val[a]);
            r[3+a] = clamp_coord(-((-sum_hi) >>> FRAC_BITS) + shift_val[a]);
        end
        return r;
    endfunction

    function automatic t_box make_box(t_coord lx, t_coord ly, t_coord lz,
                                      t_coord ux, t_coord uy, t_coord uz);
        t_box b;
        b[0] = lx;
        b[1] = ly;
        b[2] = lz;
        b[3] = ux;
        b[4] = uy;
        b[5] = uz;
        return b;
    endfunction

    // Mix of full-range, small and extreme coordinates
    function automatic t_coord random_coord();
        int unsigned pick;
        pick = $urandom_range(9, 0);
        if (pick < 4)
            return t_coord'($urandom());
        if (pick < 8)
            return t_coord'(int'($urandom_range(2097151, 0)) - 1048576);
        case ($urandom_range(4, 0))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return t_coord'(1);
        endcase
    endfunction

    // Mostly well-ordered boxes, some swapped or degenerate
    function automatic t_box random_box();
        t_box   b;
        t_coord lo, hi;
        int     k;
        for (k = 0; k < 3; k++) begin
            lo = random_coord();
            hi = random_coord();
            if ($urandom_range(19, 0) == 0)
                hi = lo;
            else if ($urandom_range(9, 0) < 7 && lo > hi) begin
                b[k]   = hi;
                hi     = lo;
                lo     = b[k];
            end
            b[k]   = lo;
            b[3+k] = hi;
        end
        return b;
    endfunction

    function automatic logic [CFG_W-1:0] random_row();
        logic [CFG_W-1:0] row;
        t_coeff           c;
        int               j;
        for (j = 0; j < 3; j++) begin
            case ($urandom_range(3, 0))
                0, 1: c = t_coeff'($urandom());
                2:    c = t_coeff'(int'($urandom_range(12288, 0)) - 6144);
                default: begin
                    case ($urandom_range(4, 0))
                        0:       c = COEFF_MAX;
                        1:       c = COEFF_MIN;
                        2:       c = '0;
                        3:       c = COEFF_ONE;
                        default: c = -COEFF_ONE;
                    endcase
                end
            endcase
            row[j*COEFF_WIDTH +: COEFF_WIDTH] = c;
        end
        return row;
    endfunction

    // Translation with random junk in the bits above the register width
    function automatic logic [CFG_W-1:0] random_shift();
        logic [63:0]      wide;
        logic [CFG_W-1:0] data;
        t_coord           v;
        wide = {$urandom(), $urandom()};
        data = wide[CFG_W-1:0];
        case ($urandom_range(9, 0))
            0:       v = COORD_MAX;
            1:       v = COORD_MIN;
            2, 3:    v = t_coord'(int'($urandom_range(2097151, 0)) - 1048576);
            default: v = t_coord'($urandom());
        endcase
        data[COORD_WIDTH-1:0] = v;
        return data;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            aat_pkg::REG_ROW_X:   coeff_row[0] = data;
            aat_pkg::REG_ROW_Y:   coeff_row[1] = data;
            aat_pkg::REG_ROW_Z:   coeff_row[2] = data;
            aat_pkg::REG_SHIFT_X: shift_val[0] = data[COORD_WIDTH-1:0];
            aat_pkg::REG_SHIFT_Y: shift_val[1] = data[COORD_WIDTH-1:0];
            aat_pkg::REG_SHIFT_Z: shift_val[2] = data[COORD_WIDTH-1:0];
            default:     ;
        endcase
    endtask

    task automatic load_random_transform();
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        write_reg(aat_pkg::REG_SHIFT_Z, random_shift());
        write_reg(aat_pkg::REG_ROW_X, random_row());
        write_reg(REG_UNUSED_A, junk[CFG_W-1:0]);
        write_reg(aat_pkg::REG_SHIFT_X, random_shift());
        write_reg(aat_pkg::REG_ROW_Z, random_row());
        write_reg(aat_pkg::REG_ROW_Y, random_row());
        write_reg(aat_pkg::REG_SHIFT_Y, random_shift());
    endtask

    task automatic push_box(t_box b);
        boxes_to_send = {boxes_to_send, b};
        boxes_queued++;
    endtask

    // Extremes, swapped bounds, rounding near zero, odd fractions
    task automatic send_directed();
        push_box(make_box('0, '0, '0, '0, '0, '0));
        push_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        push_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        push_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        push_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
        push_box(make_box(-32'sh18000, 32'sh30000, -32'sh4000, 32'sh10000, -32'sh8000, 32'sh4000));
        push_box(make_box(-32'sd1, -32'sd1, -32'sd1, 32'sd1, 32'sd1, 32'sd1));
        push_box(make_box(32'sh12345, -32'sh54321, 32'sh7_ABCD, 32'sh9_8765, 32'sh1, -32'sh1_0001));
    endtask

    // Wait for every queued box to go through, then let the pipe settle
    task automatic wait_drained();
        while (boxes_accepted != boxes_queued || expected_bounds.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Box driver: hold an offered item until it is taken
    always @(negedge i_clk) begin
        if (rst_n && (!box_valid || box_taken)) begin
            if (boxes_to_send.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                box_valid <= 1'b1;
                box_data  <= boxes_to_send.pop_front();
            end else begin
                box_valid <= 1'b0;
            end
        end
    end

    // Result ready: random back-pressure, plus one long hold-off
    always @(negedge i_clk) begin
        if (pressure_on && !pressure_done) begin
            result_ready <= 1'b0;
            hold_count   <= hold_count + 1;
            if (hold_count == HOLD_LEN - 1)
                pressure_done <= 1'b1;
        end else begin
            result_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    // Monitor: predict on input accept, compare on output accept
    always @(posedge i_clk) begin : check_results
        t_box got, want;
        logic took;
        int   k;
        took = rst_n && in_ch.valid && in_ch.ready;
        box_taken <= took;
        if (took) begin
            expected_bounds = {expected_bounds, enclose_box(box_data)};
            boxes_accepted++;
        end
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got[0] = out_ch.out_min_x;
            got[1] = out_ch.out_min_y;
            got[2] = out_ch.out_min_z;
            got[3] = out_ch.out_max_x;
            got[4] = out_ch.out_max_y;
            got[5] = out_ch.out_max_z;
            if (expected_bounds.size() == 0) begin
                $error("result item with no box pending");
                error_count++;
            end else begin
                want = expected_bounds.pop_front();
                for (k = 0; k < 6; k++) begin
                    if (got[k] !== want[k]) begin
                        $error("%s: expected %0d, actual %0d", field_name[k],
                               t_coord'(want[k]), t_coord'(got[k]));
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no traffic on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        int seg, n;
        coeff_row[0] = CFG_W'(COEFF_ONE);
        coeff_row[1] = CFG_W'(COEFF_ONE) << COEFF_WIDTH;
        coeff_row[2] = CFG_W'(COEFF_ONE) << (2 * COEFF_WIDTH);
        shift_val[0] = '0;
        shift_val[1] = '0;
        shift_val[2] = '0;
        tx_idle_pct  = 24;
        rx_idle_pct  = 71;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Identity transform left by reset
        send_directed();
        wait_drained();

        // Large and mixed-sign coefficients, junk above the shift width
        write_reg(aat_pkg::REG_ROW_X, {COEFF_MAX, COEFF_MAX, COEFF_MAX});
        write_reg(aat_pkg::REG_ROW_Y, {t_coeff'(1), COEFF_MAX, COEFF_MIN});
        write_reg(aat_pkg::REG_ROW_Z, {COEFF_MIN, -t_coeff'(1), t_coeff'(0)});
        write_reg(aat_pkg::REG_SHIFT_X, {16'hA5C3, COORD_MAX});
        write_reg(aat_pkg::REG_SHIFT_Y, {16'hFFFF, COORD_MIN});
        write_reg(aat_pkg::REG_SHIFT_Z, {16'h5A5A, t_coord'(1)});
        send_directed();
        wait_drained();

        // Most negative coefficients; writes to unmapped indexes must not land
        write_reg(aat_pkg::REG_ROW_X, {3{COEFF_MIN}});
        write_reg(aat_pkg::REG_ROW_Y, {3{COEFF_MIN}});
        write_reg(aat_pkg::REG_ROW_Z, {3{COEFF_MIN}});
        write_reg(aat_pkg::REG_SHIFT_X, {16'h0000, COORD_MIN});
        write_reg(aat_pkg::REG_SHIFT_Y, {16'h0000, COORD_MAX});
        write_reg(aat_pkg::REG_SHIFT_Z, {16'h0000, -t_coord'(1)});
        write_reg(REG_UNUSED_A, {CFG_W{1'b1}});
        write_reg(REG_UNUSED_B, {CFG_W{1'b1}});
        send_directed();
        wait_drained();

        // Random boxes under a fresh transform per segment
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 2) begin
                tx_idle_pct = 71;
                rx_idle_pct = 24;
            end else if (seg == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            load_random_transform();
            for (n = 0; n < SEGMENT_BOXES; n++)
                push_box(random_box());
            if (seg == 4)
                pressure_on = 1'b1;
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/aat_pkg.sv
src/aat_in_if.sv
src/aat_out_if.sv
src/aat_cfg_regs.sv
src/aat_sort.sv
src/aat_mul.sv
src/aat_sum.sv
src/aat_round.sv
src/affine_aabb_transform_top.sv
verif/tb_affine_aabb_transform_top.sv
